>>> design/jac_pkg.sv
// shared constants and types for the jacobi symbol unit
`timescale 1ns / 1ps

package jac_pkg;

    // default operand width
    localparam int OPERAND_BITS_DEF = 31;

    // two's complement codes of the symbol field
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    // control of the bit-serial subtractor
    typedef struct packed {
        logic en;     // one bit pair enters this cycle
        logic first;  // least significant bit of a pass, borrow in is zero
    } jac_sub_ctl_t;

endpackage

>>> design/jac_dual_sub.sv
// bit-serial subtractor forming x - y and y - x one bit per cycle while ctl.en is high
`timescale 1ns / 1ps

module jac_dual_sub
    import jac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  jac_sub_ctl_t ctl,
    input  logic         x_bit,
    input  logic         y_bit,
    output logic         xy_diff,
    output logic         yx_diff,
    output logic         xy_borrow
);

    logic xy_borrow_reg;
    logic xy_borrow_next;
    logic yx_borrow_reg;
    logic yx_borrow_next;
    logic xy_bin;
    logic yx_bin;

    // borrow in is zero on the lowest bit
    assign xy_bin = ctl.first ? 1'b0 : xy_borrow_reg;
    assign yx_bin = ctl.first ? 1'b0 : yx_borrow_reg;

    // full subtractor cells
    always_comb
    begin
        xy_diff        = x_bit ^ y_bit ^ xy_bin;
        yx_diff        = x_bit ^ y_bit ^ yx_bin;
        xy_borrow_next = (~x_bit & y_bit) | (~(x_bit ^ y_bit) & xy_bin);
        yx_borrow_next = (~y_bit & x_bit) | (~(x_bit ^ y_bit) & yx_bin);
    end

    // carried borrows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_borrow_reg <= 1'b0;
            yx_borrow_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            xy_borrow_reg <= xy_borrow_next;
            yx_borrow_reg <= yx_borrow_next;
        end
    end

    // final borrow of x - y tells x < y after a full pass
    assign xy_borrow = xy_borrow_reg;

endmodule

>>> design/jacobi_symbol.sv
// top level of the jacobi symbol unit
//
// Computes the Jacobi symbol (numerator / modulus) with the binary algorithm.
// Input beat: numerator and modulus are taken at a rising edge with start
// high and busy low. Result beat: symbol (-1, 0, +1 in two's complement) and
// bad_modulus are shown for exactly one cycle while done is high; the
// receiver cannot stall, so the result must be taken in that cycle.
// A zero or even modulus gives bad_modulus with symbol 0 in the cycle after
// the beat is accepted, and busy stays low.
// Otherwise the unit alternates halving steps with subtraction passes that
// stream all OPERAND_BITS bits of both operands through a bit-serial
// subtractor, each pass followed by a commit step that keeps the difference
// or swaps. The run time depends on the operands: at most about
// 2 * OPERAND_BITS passes plus the halving steps.
// One item is in work at a time; busy is high from acceptance until the
// cycle done rises.
// Reset clears the control state and drops busy and done.
`timescale 1ns / 1ps

module jacobi_symbol
    import jac_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OPERAND_BITS-1:0] numerator,
    input  logic [OPERAND_BITS-1:0] modulus,
    output logic                    done,
    output logic signed [1:0]       symbol,
    output logic                    bad_modulus
);

    localparam int CNT_W = $clog2(OPERAND_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);
    localparam logic [OPERAND_BITS-1:0] ONE_VAL = OPERAND_BITS'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HALVE,
        ST_SUB,
        ST_COMMIT
    } state_t;

    state_t                  state_reg;
    logic [OPERAND_BITS-1:0] a_reg;
    logic [OPERAND_BITS-1:0] m_reg;
    logic [OPERAND_BITS-1:0] d1_reg;
    logic [OPERAND_BITS-1:0] d2_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic                    done_reg;
    logic [1:0]              symbol_reg;
    logic                    bad_reg;

    jac_sub_ctl_t sub_ctl;
    logic         xy_diff;
    logic         yx_diff;
    logic         a_lt_m;
    logic         m_flip;
    logic         recip_flip;

    // serial subtractor fed from the low ends of the rotating operands
    assign sub_ctl.en    = (state_reg == ST_SUB);
    assign sub_ctl.first = (state_reg == ST_SUB) && (cnt_reg == '0);

    jac_dual_sub u_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sub_ctl),
        .x_bit     (a_reg[0]),
        .y_bit     (m_reg[0]),
        .xy_diff   (xy_diff),
        .yx_diff   (yx_diff),
        .xy_borrow (a_lt_m)
    );

    // sign rules on the low bits of the modulus and the numerator
    assign m_flip     = (m_reg[2:0] == 3'd3) || (m_reg[2:0] == 3'd5);
    assign recip_flip = (a_reg[1:0] == 2'b11) && (m_reg[1:0] == 2'b11);

    // sequencer, operand shift registers and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            a_reg      <= '0;
            m_reg      <= '0;
            d1_reg     <= '0;
            d2_reg     <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            symbol_reg <= SYM_ZERO;
            bad_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        a_reg   <= numerator;
                        m_reg   <= modulus;
                        neg_reg <= 1'b0;
                        if (!modulus[0])
                        begin
                            done_reg   <= 1'b1;
                            bad_reg    <= 1'b1;
                            symbol_reg <= SYM_ZERO;
                        end
                        else
                        begin
                            state_reg <= ST_HALVE;
                        end
                    end
                end
                ST_HALVE:
                begin
                    if (a_reg == '0)
                    begin
                        // finished: gcd is one only when the modulus fell to one
                        done_reg  <= 1'b1;
                        bad_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                        if (m_reg != ONE_VAL)
                            symbol_reg <= SYM_ZERO;
                        else
                            symbol_reg <= neg_reg ? SYM_NEG : SYM_POS;
                    end
                    else if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        if (m_flip)
                            neg_reg <= ~neg_reg;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB:
                begin
                    // rotate operands, collect both differences lsb first
                    a_reg  <= {a_reg[0], a_reg[OPERAND_BITS-1:1]};
                    m_reg  <= {m_reg[0], m_reg[OPERAND_BITS-1:1]};
                    d1_reg <= {xy_diff, d1_reg[OPERAND_BITS-1:1]};
                    d2_reg <= {yx_diff, d2_reg[OPERAND_BITS-1:1]};
                    if (cnt_reg == CNT_LAST)
                        state_reg <= ST_COMMIT;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_COMMIT:
                begin
                    if (a_lt_m)
                    begin
                        // swap with reciprocity: new pair is (m - a, a)
                        a_reg <= d2_reg;
                        m_reg <= a_reg;
                        if (recip_flip)
                            neg_reg <= ~neg_reg;
                    end
                    else
                    begin
                        a_reg <= d1_reg;
                    end
                    state_reg <= ST_HALVE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign symbol      = symbol_reg;
    assign bad_modulus = done_reg & bad_reg;

    // a result beat never overlaps work in progress
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // a bad modulus always reports a zero symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        bad_modulus |-> (done && symbol == SYM_ZERO))
        else $error("bad modulus with nonzero symbol");

    // an accepted beat either starts work or answers at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat lost");

    // the modulus stays odd through every halving step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HALVE) |-> m_reg[0])
        else $error("modulus became even");

endmodule
